@@ design/energy_vad_endpoint_detector_top_defines.svh @@
// ----------------------------------------------------------------------------
// energy vad endpoint detector - assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef ENERGY_VAD_ENDPOINT_DETECTOR_TOP_DEFINES_SVH
`define ENERGY_VAD_ENDPOINT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define EVAD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evad assertion failed");

// next-cycle implication, ignored while in reset
`define EVAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evad assertion failed");

`endif

@@ design/evad_pkg.sv @@
// ----------------------------------------------------------------------------
// evad_pkg
// types and fixed constants of the energy vad endpoint detector
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int OPC_W      = 2;
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int ACT_W      = 2;
  localparam int SEG_W      = 24;
  localparam int THR_W      = 30;
  localparam int SIL_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [OPC_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_HOLD   = 2'd0,
    ACT_SUBMIT = 2'd1,
    ACT_DRAIN  = 2'd2,
    ACT_BUSY   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_SQ = 2'd0,
    CFG_SILENCE_TICKS = 2'd1,
    CFG_MIN_SEGMENT  = 2'd2,
    CFG_MAX_SEGMENT  = 2'd3
  } cfg_idx_t;

  localparam logic [THR_W-1:0] THR_RESET      = 30'd154610;
  localparam logic [SIL_W-1:0] SIL_NEED_RESET = 8'd2;
  localparam logic [SEG_W-1:0] MIN_SEG_RESET  = 24'd12000;
  localparam logic [SEG_W-1:0] MAX_SEG_RESET  = 24'd192000;

endpackage

@@ design/energy_vad_endpoint_detector_top.sv @@
// ----------------------------------------------------------------------------
// energy_vad_endpoint_detector_top
// energy voice activity detector with end-of-utterance decision
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel: pcm samples accumulate their
// square into the tick energy, a tick classifies the tick as voiced when
// energy >= threshold_sq * samples_in_tick and returns one result word
// (hold, submit, drain or busy skip); restart clears the detector state. A sample is
// squared on its way into the input register; the state-update logic then consumes
// each word from there, and a tick writes the result register as it is consumed, so
// a tick result passes through the input register and then the result register.
// Throughput is one word per cycle while the input does not stall; the tick decision
// holds one threshold x tick-count multiply and a compare. The input stalls only
// while a tick sits in the input register and the result register is still held
// by the sink. There is no clearing pass after reset.
module energy_vad_endpoint_detector_top #(
  parameter int COUNT_WIDTH  = 24,
  parameter int ENERGY_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [evad_pkg::OPC_W-1:0]          in_opcode,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_engine_busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [evad_pkg::ACT_W-1:0]          out_action,
  output logic [evad_pkg::SEG_W-1:0]          out_segment_samples,
  output logic                                out_tick_voiced,
  output logic                                out_speech_active,
  output logic [evad_pkg::SIL_W-1:0]          out_silent_tick_count,
  input  logic                                cfg_we,
  input  logic [evad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import evad_pkg::*;

  localparam int PROD_W = THR_W + COUNT_WIDTH;
  localparam int CMP_W  = (PROD_W > ENERGY_WIDTH) ? PROD_W : ENERGY_WIDTH;
  localparam int BUF_W  = (COUNT_WIDTH > SEG_W) ? COUNT_WIDTH : SEG_W;

  // configuration
  logic [THR_W-1:0] thr_r;
  logic [SIL_W-1:0] sil_need_r;
  logic [SEG_W-1:0] min_seg_r;
  logic [SEG_W-1:0] max_seg_r;

  // input register
  logic             in_vld_r, in_vld_nxt;
  logic [OPC_W-1:0] op_r;
  logic [SQ_W-1:0]  sq_r;
  logic             busy_r;
  logic [SAMPLE_W-1:0] mag;

  // detector state
  logic [ENERGY_WIDTH-1:0] energy_r, energy_nxt;
  logic [COUNT_WIDTH-1:0]  tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0]  buf_r, buf_nxt;
  logic                    speech_r, speech_nxt;
  logic [SIL_W-1:0]        sil_r, sil_nxt;

  // result register
  logic             out_vld_r, out_vld_nxt;
  logic [ACT_W-1:0] act_r;
  logic [SEG_W-1:0] seg_r;
  logic             voiced_r, spa_r;
  logic [SIL_W-1:0] stc_r;

  logic              is_tick, proc_go, res_v;
  action_t           act_c;
  logic              voiced_c;
  logic [ENERGY_WIDTH:0] energy_add;
  logic [PROD_W-1:0] prod;
  logic              end_utt, ovf, min_ok;

  assign is_tick  = (opcode_t'(op_r) == OP_TICK);
  assign proc_go  = in_vld_r && (!is_tick || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc_go;

  // |sample|, -32768 maps to 0x8000
  assign mag = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;

  assign energy_add = {1'b0, energy_r} + (ENERGY_WIDTH+1)'(sq_r);
  assign prod       = PROD_W'(thr_r) * PROD_W'(tick_r);
  assign ovf        = BUF_W'(buf_r) >= BUF_W'(max_seg_r);
  assign min_ok     = BUF_W'(buf_r) >= BUF_W'(min_seg_r);

  always_comb begin
    energy_nxt = energy_r;
    tick_nxt   = tick_r;
    buf_nxt    = buf_r;
    speech_nxt = speech_r;
    sil_nxt    = sil_r;
    res_v      = 1'b0;
    act_c      = ACT_HOLD;
    voiced_c   = 1'b0;
    end_utt    = 1'b0;
    if (proc_go) begin
      case (opcode_t'(op_r))
        OP_SAMPLE: begin
          energy_nxt = energy_add[ENERGY_WIDTH] ? '1 : energy_add[ENERGY_WIDTH-1:0];
          tick_nxt   = (tick_r == '1) ? tick_r : tick_r + 1'b1;
          buf_nxt    = (buf_r == '1) ? buf_r : buf_r + 1'b1;
        end
        OP_RESTART: begin
          energy_nxt = '0;
          tick_nxt   = '0;
          buf_nxt    = '0;
          speech_nxt = 1'b0;
          sil_nxt    = '0;
        end
        OP_TICK: begin
          res_v = 1'b1;
          if (busy_r) begin
            act_c = ACT_BUSY;
          end else begin
            voiced_c   = CMP_W'(energy_r) >= CMP_W'(prod);
            energy_nxt = '0;
            tick_nxt   = '0;
            if (voiced_c) begin
              speech_nxt = 1'b1;
              sil_nxt    = '0;
            end else if (speech_r && sil_r != '1) begin
              sil_nxt = sil_r + 1'b1;
            end
            end_utt = speech_nxt && (sil_nxt >= sil_need_r);
            if (ovf && !speech_nxt) begin
              act_c   = ACT_DRAIN;
              buf_nxt = '0;
              sil_nxt = '0;
            end else if ((end_utt || ovf) && min_ok) begin
              act_c      = ACT_SUBMIT;
              buf_nxt    = '0;
              speech_nxt = 1'b0;
              sil_nxt    = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (proc_go) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
    if (res_v) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      energy_r   <= '0;
      tick_r     <= '0;
      buf_r      <= '0;
      speech_r   <= 1'b0;
      sil_r      <= '0;
      thr_r      <= THR_RESET;
      sil_need_r <= SIL_NEED_RESET;
      min_seg_r  <= MIN_SEG_RESET;
      max_seg_r  <= MAX_SEG_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      energy_r  <= energy_nxt;
      tick_r    <= tick_nxt;
      buf_r     <= buf_nxt;
      speech_r  <= speech_nxt;
      sil_r     <= sil_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD_SQ:  thr_r      <= cfg_wdata[THR_W-1:0];
          CFG_SILENCE_TICKS: sil_need_r <= cfg_wdata[SIL_W-1:0];
          CFG_MIN_SEGMENT:   min_seg_r  <= cfg_wdata[SEG_W-1:0];
          CFG_MAX_SEGMENT:   max_seg_r  <= cfg_wdata[SEG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      sq_r   <= SQ_W'(mag) * SQ_W'(mag);
      busy_r <= in_engine_busy;
    end
    if (res_v) begin
      act_r    <= act_c;
      seg_r    <= SEG_W'(buf_r);
      voiced_r <= voiced_c;
      spa_r    <= speech_nxt;
      stc_r    <= sil_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_action            = act_r;
  assign out_segment_samples   = seg_r;
  assign out_tick_voiced       = voiced_r;
  assign out_speech_active     = spa_r;
  assign out_silent_tick_count = stc_r;

endmodule

@@ design/evad_checker.sv @@
// ----------------------------------------------------------------------------
// evad_checker
// port-level checks on the result channel of the endpoint detector
// ----------------------------------------------------------------------------
`include "energy_vad_endpoint_detector_top_defines.svh"

module evad_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [evad_pkg::ACT_W-1:0] out_action,
  input logic [evad_pkg::SEG_W-1:0] out_segment_samples,
  input logic                       out_tick_voiced,
  input logic                       out_speech_active,
  input logic [evad_pkg::SIL_W-1:0] out_silent_tick_count
);
  import evad_pkg::*;

  // stalled result word holds
  `EVAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_action) && $stable(out_segment_samples))

  // a drain leaves no silence run and no speech
  `EVAD_ASSERT_IMPL(a_drain_clear, out_valid && out_action == ACT_DRAIN, !out_speech_active && out_silent_tick_count == '0)

  // a submit ends the utterance
  `EVAD_ASSERT_IMPL(a_submit_clear, out_valid && out_action == ACT_SUBMIT, !out_speech_active && out_silent_tick_count == '0)

  // a voiced tick that holds marks speech and restarts the silence run
  `EVAD_ASSERT_IMPL(a_voiced_hold, out_valid && out_tick_voiced && out_action == ACT_HOLD, out_speech_active && out_silent_tick_count == '0)

endmodule

bind energy_vad_endpoint_detector_top evad_checker u_evad_checker (.*);
